@@ rtl/csv_pkg.sv @@
// ----------------------------------------------------------------------------
// csv_pkg - shared types and constants for the clip-space visibility core
// Coordinate format, pipeline latencies and the failing-axis codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int MAT_REGS      = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_W         = 64;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int BOUND_W       = COORD_W + 2;

    // pipeline depths of the three sections
    localparam int XF_LAT  = 3;
    localparam int DIV_LAT = COORD_W + 3;
    localparam int BND_LAT = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

endpackage

`default_nettype wire

@@ rtl/csv_xform.sv @@
// ----------------------------------------------------------------------------
// csv_xform - matrix transform of one point per cycle while advance is high
// Holds the matrix registers; multiply, add pairs, add and scale/saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_xform #(
    parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [csv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csv_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           advance,
    input  wire csv_pkg::coord_t [3:0]          point,
    output csv_pkg::coord_t [3:0]               clip
);

    localparam int PW = csv_pkg::PROD_W;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic [csv_pkg::CFG_W-1:0] mat_reg [csv_pkg::MAT_REGS];

    logic signed [PW-1:0]   prod_next [4][4];
    logic signed [PW-1:0]   prod_reg  [4][4];
    logic signed [PW:0]     pair_next [4][2];
    logic signed [PW:0]     pair_reg  [4][2];
    csv_pkg::coord_t [3:0]  clip_next;
    csv_pkg::coord_t [3:0]  clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < csv_pkg::MAT_REGS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (cfg_we && cfg_index < csv_pkg::CFG_IDX_W'(csv_pkg::MAT_REGS))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] scaled;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] =
                    PW'(csv_pkg::coord_t'(mat_reg[r*2 + c/2][(c%2)*32 +: 32])) *
                    PW'(point[c]);
            end
            for (int k = 0; k < 2; k++)
            begin
                pair_next[r][k] = (PW+1)'(prod_reg[r][2*k]) +
                                  (PW+1)'(prod_reg[r][2*k+1]);
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            sum    = SW'(pair_reg[r][0]) + SW'(pair_reg[r][1]);
            scaled = sum >>> FRAC_BITS;
            if (scaled > SAT_MAX)
                clip_next[r] = csv_pkg::coord_t'(SAT_MAX[31:0]);
            else if (scaled < SAT_MIN)
                clip_next[r] = csv_pkg::coord_t'(SAT_MIN[31:0]);
            else
                clip_next[r] = scaled[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            clip_reg <= clip_next;
        end
    end

    assign clip = clip_reg;

endmodule

`default_nettype wire

@@ rtl/csv_divider.sv @@
// ----------------------------------------------------------------------------
// csv_divider - pipelined signed Q-format divide, one quotient bit per stage
// Computes sat32((v << FRAC_BITS) / w); passes v through when w is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_divider #(
    parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               advance,
    input  wire csv_pkg::coord_t    v,
    input  wire csv_pkg::coord_t    w,
    output csv_pkg::coord_t         res
);

    localparam int CW = csv_pkg::COORD_W;

    // prep stage
    logic [CW-1:0]    mag_reg;
    logic [CW-1:0]    den_reg  [CW+1];
    logic             neg_reg  [CW+1];
    logic             byp_reg  [CW+1];
    logic             p_byp_reg;
    logic             p_neg_reg;
    logic [CW-1:0]    p_den_reg;
    csv_pkg::coord_t  v_reg    [CW+1];
    csv_pkg::coord_t  p_v_reg;
    logic             ovf_reg  [CW+1];
    logic [CW-1:0]    rem_reg  [CW+1];
    logic [CW-1:0]    lo_reg   [CW+1];
    logic [CW-1:0]    q_reg    [CW+1];
    csv_pkg::coord_t  res_reg;
    csv_pkg::coord_t  res_next;

    // stage: magnitudes and sign
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg   <= v[CW-1] ? CW'(-v) : v;
            p_den_reg <= w[CW-1] ? CW'(-w) : w;
            p_neg_reg <= v[CW-1] ^ w[CW-1];
            p_byp_reg <= (w == '0);
            p_v_reg   <= v;
        end
    end

    // stage: overflow test and initial remainder
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= mag_reg >> (CW - FRAC_BITS);
            lo_reg[0]  <= mag_reg << FRAC_BITS;
            ovf_reg[0] <= (mag_reg >> (CW - FRAC_BITS)) >= p_den_reg;
            q_reg[0]   <= '0;
            den_reg[0] <= p_den_reg;
            neg_reg[0] <= p_neg_reg;
            byp_reg[0] <= p_byp_reg;
            v_reg[0]   <= p_v_reg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < CW; i++)
    begin : g_bit
        logic [CW:0] trial;
        logic        ge;

        assign trial = {rem_reg[i], lo_reg[i][CW-1]};
        assign ge    = trial >= {1'b0, den_reg[i]};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i+1] <= ge ? CW'(trial - {1'b0, den_reg[i]}) : trial[CW-1:0];
                lo_reg[i+1]  <= {lo_reg[i][CW-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][CW-2:0], ge};
                ovf_reg[i+1] <= ovf_reg[i];
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                byp_reg[i+1] <= byp_reg[i];
                v_reg[i+1]   <= v_reg[i];
            end
        end
    end

    // apply sign and saturate
    always_comb
    begin
        logic [CW-1:0] q;
        q = q_reg[CW];
        if (byp_reg[CW])
            res_next = v_reg[CW];
        else if (neg_reg[CW])
        begin
            if (ovf_reg[CW] || q > {1'b1, {(CW-1){1'b0}}})
                res_next = {1'b1, {(CW-1){1'b0}}};
            else
                res_next = CW'(-q);
        end
        else
        begin
            if (ovf_reg[CW] || q[CW-1])
                res_next = {1'b0, {(CW-1){1'b1}}};
            else
                res_next = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ rtl/csv_bounds.sv @@
// ----------------------------------------------------------------------------
// csv_bounds - widened clip-volume test
// Forms the margin bounds, then compares x, y, z and picks the first failure.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_bounds #(
    parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   advance,
    input  wire csv_pkg::coord_t [2:0]  coord,
    input  wire csv_pkg::coord_t        margin,
    output logic                        in_view,
    output csv_pkg::axis_t              failing_axis
);

    localparam int BW = csv_pkg::BOUND_W;
    localparam logic signed [BW-1:0] ONE = BW'(1) <<< FRAC_BITS;

    logic signed [BW-1:0]   lo_xy_reg;
    logic signed [BW-1:0]   hi_reg;
    logic signed [BW-1:0]   lo_z_reg;
    csv_pkg::coord_t [2:0]  coord_reg;
    csv_pkg::axis_t         axis_next;
    csv_pkg::axis_t         axis_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_xy_reg <= -ONE - BW'(margin);
            hi_reg    <= ONE + BW'(margin);
            lo_z_reg  <= -BW'(margin);
            coord_reg <= coord;
        end
    end

    always_comb
    begin
        if (BW'(coord_reg[0]) < lo_xy_reg || BW'(coord_reg[0]) > hi_reg)
            axis_next = csv_pkg::AXIS_X;
        else if (BW'(coord_reg[1]) < lo_xy_reg || BW'(coord_reg[1]) > hi_reg)
            axis_next = csv_pkg::AXIS_Y;
        else if (BW'(coord_reg[2]) < lo_z_reg || BW'(coord_reg[2]) > hi_reg)
            axis_next = csv_pkg::AXIS_Z;
        else
            axis_next = csv_pkg::AXIS_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            axis_reg <= axis_next;
        end
    end

    assign failing_axis = axis_reg;
    assign in_view      = (axis_reg == csv_pkg::AXIS_NONE);

endmodule

`default_nettype wire

@@ rtl/clip_space_point_visibility_test_core.sv @@
// ----------------------------------------------------------------------------
// clip_space_point_visibility_test_core - frustum test of homogeneous points
// Transforms each point by a 4x4 matrix, divides by clip w and tests it
// against the clip volume widened by a per-point margin.
// ----------------------------------------------------------------------------
//  channel   | direction | word contents (low bit first)
//  s_axis    | in        | point_x, point_y, point_z, point_w, margin (160 b)
//  m_axis    | out       | in_view, failing_axis, zero pad (8 b)
//  cfg       | in        | write enable, index 0..7, 64-bit matrix half-row
//
//  One word enters per cycle; each result passes through 3 transform, 35
//  divider and 2 bounds stages. The divider, one quotient bit
//  per stage, sets the depth. Reset clears the matrix and all valid bits.
//  When the output word is held, the whole pipeline freezes: nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_space_point_visibility_test_core #(
    parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [csv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csv_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, point_w, margin
    input  wire logic [159:0]                   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // in_view, failing_axis[1:0], five zero bits
    output logic [7:0]                          m_tdata
);

    localparam int PRE_LAT = csv_pkg::XF_LAT + csv_pkg::DIV_LAT;
    localparam int LAT     = PRE_LAT + csv_pkg::BND_LAT;

    logic                   advance;
    logic                   vld_reg [LAT];
    csv_pkg::coord_t        mdl_reg [PRE_LAT];
    csv_pkg::coord_t [3:0]  point;
    csv_pkg::coord_t [3:0]  clip;
    csv_pkg::coord_t [2:0]  ndc;
    logic                   in_view;
    csv_pkg::axis_t         failing_axis;

    // advance everything when the output register is empty or being taken
    assign advance  = !vld_reg[LAT-1] || m_tready;
    assign s_tready = advance;

    for (genvar i = 0; i < 4; i++)
    begin : g_pt
        assign point[i] = s_tdata[i*32 +: 32];
    end

    // valid bits ride alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // delay the margin to meet the divided coordinates
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mdl_reg[0] <= s_tdata[159:128];
            for (int i = 1; i < PRE_LAT; i++)
            begin
                mdl_reg[i] <= mdl_reg[i-1];
            end
        end
    end

    csv_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .point     (point),
        .clip      (clip)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        csv_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk     (clk),
            .advance (advance),
            .v       (clip[a]),
            .w       (clip[3]),
            .res     (ndc[a])
        );
    end

    csv_bounds #(.FRAC_BITS(FRAC_BITS)) u_bounds (
        .clk          (clk),
        .advance      (advance),
        .coord        (ndc),
        .margin       (mdl_reg[PRE_LAT-1]),
        .in_view      (in_view),
        .failing_axis (failing_axis)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {5'b0, failing_axis, in_view};

`ifndef SYNTHESIS
    a_view_axis: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == csv_pkg::AXIS_NONE)))
        else $error("in_view disagrees with failing_axis");

    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !m_tready && m_tvalid) |=> vld_reg[0])
        else $error("first stage dropped a word during stall");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'b0))
        else $error("pad bits of output word not zero");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && vld_reg[PRE_LAT-1]) |=> vld_reg[PRE_LAT-1])
        else $error("divider output word lost during stall");
`endif

endmodule

`default_nettype wire
